/* src/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for point projection to screen
// Payload structs, register indexes, fixed-point widths.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int COEFF_FRAC_BITS_DEF = 10;
    localparam int POS_FRAC_BITS_DEF   = 4;
    localparam int SPRITE_HALF         = 4;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 64;
    localparam int VIEW_W              = 10;
    // clip value: 16x16 products, sum of four -> 34 bits
    localparam int CLIP_W              = 34;
    // numerator cx+w fits 35 bits unsigned in range, times 10-bit size
    localparam int NUM_W               = 36;
    localparam int DEN_W               = 36;
    localparam int QUO_W               = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_H = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y  = 3'd7;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [1:0]         sprite_sel;
    } t_in_item;

    typedef struct packed {
        logic signed [11:0] screen_x;
        logic signed [11:0] screen_y;
        logic [1:0]         sprite_out;
    } t_out_item;

    // classified point handed from front to back
    typedef struct packed {
        logic [NUM_W-1:0]  num_x;
        logic [NUM_W-1:0]  num_y;
        logic [DEN_W-1:0]  den;
        logic [VIEW_W-1:0] size_x;
        logic [VIEW_W-1:0] size_y;
        logic [VIEW_W-1:0] off_x;
        logic [VIEW_W-1:0] off_y;
        logic [1:0]        sprite;
    } t_job;

endpackage

/* src/pps_front.sv */
// ----------------------------------------------------------------------------
// pps_front: matrix transform and clip test
// Three stages: products, row sums, clip classification. Drops culled points.
// ----------------------------------------------------------------------------
module pps_front #(
    parameter int COEFF_FRAC_BITS = pps_pkg::COEFF_FRAC_BITS_DEF,
    parameter int POS_FRAC_BITS   = pps_pkg::POS_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pps_pkg::t_in_item  i_item,
    input  logic               i_adv,
    input  logic [63:0]        i_row_x,
    input  logic [63:0]        i_row_y,
    input  logic [63:0]        i_row_w,
    input  logic [9:0]         i_size_x,
    input  logic [9:0]         i_size_y,
    input  logic [9:0]         i_off_x,
    input  logic [9:0]         i_off_y,
    output logic               o_valid,
    output pps_pkg::t_job      o_job
);
    localparam int CW = pps_pkg::CLIP_W;
    localparam int FB = COEFF_FRAC_BITS + POS_FRAC_BITS;

    logic                 r_v1, r_v2, r_v3;
    logic signed [31:0]   r_p [3][4];
    logic [1:0]           r_s1, r_s2;
    logic signed [CW-1:0] r_cx, r_cy, r_cw;
    pps_pkg::t_job        r_job;
    logic signed [15:0]   w_pos [4];
    logic signed [CW-1:0] w_sum [3];
    logic signed [CW+10:0] w_w1000, w_lim;
    logic                 w_keep;
    logic signed [CW+1:0] w_nx, w_ny, w_dn;

    always_comb begin
        w_pos[0] = i_item.pos_x;
        w_pos[1] = i_item.pos_y;
        w_pos[2] = i_item.pos_z;
        w_pos[3] = 16'sd1 <<< POS_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < 4; c++) begin
                r_p[0][c] <= $signed(i_row_x[16*c +: 16]) * w_pos[c];
                r_p[1][c] <= $signed(i_row_y[16*c +: 16]) * w_pos[c];
                r_p[2][c] <= $signed(i_row_w[16*c +: 16]) * w_pos[c];
            end
            r_s1  <= i_item.sprite_sel;
            r_cx  <= w_sum[0];
            r_cy  <= w_sum[1];
            r_cw  <= w_sum[2];
            r_s2  <= r_s1;
            r_job.num_x  <= pps_pkg::NUM_W'(w_nx);
            r_job.num_y  <= pps_pkg::NUM_W'(w_ny);
            r_job.den    <= pps_pkg::DEN_W'(w_dn);
            r_job.size_x <= i_size_x;
            r_job.size_y <= i_size_y;
            r_job.off_x  <= i_off_x;
            r_job.off_y  <= i_off_y;
            r_job.sprite <= r_s2;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = CW'(r_p[r][0]) + CW'(r_p[r][1]) + CW'(r_p[r][2]) + CW'(r_p[r][3]);
        end
        w_w1000 = (CW+11)'(r_cw) * (CW+11)'(1000);
        w_lim   = (CW+11)'(1) <<< FB;
        w_nx = (CW+2)'(r_cx) + (CW+2)'(r_cw);
        w_ny = (CW+2)'(r_cw) - (CW+2)'(r_cy);
        w_dn = (CW+2)'(r_cw) <<< 1;
        w_keep = (w_w1000 > w_lim) && !(r_cx < -r_cw) && !(r_cx > r_cw)
              && !(r_cy < -r_cw) && !(r_cy > r_cw);
    end

    assign o_valid = r_v3;
    assign o_job   = r_job;
endmodule

/* src/pps_queue.sv */
// ----------------------------------------------------------------------------
// pps_queue: small FIFO between front and back
// Eight entries; reports its fill count for the front's room check.
// ----------------------------------------------------------------------------
module pps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  pps_pkg::t_job i_job,
    input  logic          i_rd,
    output logic          o_valid,
    output pps_pkg::t_job o_job,
    output logic [3:0]    o_count
);
    pps_pkg::t_job r_mem [8];
    logic [2:0]    r_wp, r_rp;
    logic [3:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 3'd1;
            if (i_rd) r_rp <= r_rp + 3'd1;
            r_cnt <= r_cnt + {3'd0, i_wr} - {3'd0, i_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_job;
    end

    assign o_valid = r_cnt != 4'd0;
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule

/* src/pps_back.sv */
// ----------------------------------------------------------------------------
// pps_back: viewport scaling
// Pipelined restoring divider, one quotient bit per stage, both axes in step.
// ----------------------------------------------------------------------------
module pps_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pps_pkg::t_job     i_job,
    input  logic              i_adv,
    output logic              o_valid,
    output pps_pkg::t_out_item o_item
);
    localparam int NW = pps_pkg::NUM_W + 10;
    localparam int DW = pps_pkg::DEN_W;
    localparam int QW = pps_pkg::QUO_W;
    localparam int NS = QW + 1;

    logic [NS-1:0]    r_v;
    logic [NW-1:0]    r_rx [NS], r_ry [NS];
    logic [DW-1:0]    r_dn [NS];
    logic [QW-1:0]    r_qx [NS], r_qy [NS];
    logic [9:0]       r_ox [NS], r_oy [NS];
    logic [1:0]       r_sp [NS];
    pps_pkg::t_out_item r_out;
    logic             r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_adv) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_ov <= r_v[NS-1];
        end
    end

    // stage 0: products; stages 1..QW: one quotient bit each (MSB first)
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rx[0] <= NW'(i_job.num_x * i_job.size_x);
            r_ry[0] <= NW'(i_job.num_y * i_job.size_y);
            r_dn[0] <= i_job.den;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_ox[0] <= i_job.off_x;
            r_oy[0] <= i_job.off_y;
            r_sp[0] <= i_job.sprite;
            for (int s = 1; s < NS; s++) begin
                logic [NW+QW-1:0] dsh;
                dsh = (NW+QW)'(r_dn[s-1]) << (QW - s);
                if ((NW+QW)'(r_rx[s-1]) >= dsh && r_dn[s-1] != '0) begin
                    r_rx[s] <= NW'((NW+QW)'(r_rx[s-1]) - dsh);
                    r_qx[s] <= r_qx[s-1] | (QW'(1) << (QW - s));
                end else begin
                    r_rx[s] <= r_rx[s-1];
                    r_qx[s] <= r_qx[s-1];
                end
                if ((NW+QW)'(r_ry[s-1]) >= dsh && r_dn[s-1] != '0) begin
                    r_ry[s] <= NW'((NW+QW)'(r_ry[s-1]) - dsh);
                    r_qy[s] <= r_qy[s-1] | (QW'(1) << (QW - s));
                end else begin
                    r_ry[s] <= r_ry[s-1];
                    r_qy[s] <= r_qy[s-1];
                end
                r_dn[s] <= r_dn[s-1];
                r_ox[s] <= r_ox[s-1];
                r_oy[s] <= r_oy[s-1];
                r_sp[s] <= r_sp[s-1];
            end
            r_out.screen_x   <= 12'(r_qx[NS-1]) + 12'(r_ox[NS-1])
                                - 12'(pps_pkg::SPRITE_HALF);
            r_out.screen_y   <= 12'(r_qy[NS-1]) + 12'(r_oy[NS-1])
                                - 12'(pps_pkg::SPRITE_HALF);
            r_out.sprite_out <= r_sp[NS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;
endmodule

/* src/point_project_to_screen_top.sv */
// ----------------------------------------------------------------------------
// point_project_to_screen_top: world point to sprite screen position
// Transform, clip, and viewport mapping of one point per cycle while nothing stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_stall, i_item) carries a world point and sprite.
//   Output channel (o_valid/i_stall, o_item) carries the sprite top-left pixel.
//   Culled points (w at or below 0.001, or outside the clip square) give no
//   transfer. Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_data) are registered
//   and must only happen while the block is idle.
//   Throughput: one point per cycle while nothing stalls. Path: 3 front stages,
//   the queue, then 13 back stages (product plus 11 quotient bits plus output
//   register).
//   The back pipeline advances only when its output register is empty or
//   being taken; the front pipeline advances while the queue has room for
//   every point still inside the front stages.
//   Reset (synchronous, active low) empties all stages and loads the
//   identity matrix and a 320x240 viewport at offset zero.
//   A stalled receiver holds o_item steady; points pile into the queue and
//   then the front stalls the sender.
// ----------------------------------------------------------------------------
module point_project_to_screen_top #(
    parameter int COEFF_FRAC_BITS = pps_pkg::COEFF_FRAC_BITS_DEF,
    parameter int POS_FRAC_BITS   = pps_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  pps_pkg::t_in_item                i_item,
    output logic                             o_valid,
    input  logic                             i_stall,
    output pps_pkg::t_out_item               o_item,
    input  logic                             i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    logic [63:0] r_row_x, r_row_y, r_row_z, r_row_w;
    logic [9:0]  r_vw, r_vh, r_ox, r_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= 64'd1024;
            r_row_y <= 64'd67108864;
            r_row_z <= 64'd4398046511104;
            r_row_w <= 64'd288230376151711744;
            r_vw    <= 10'd320;
            r_vh    <= 10'd240;
            r_ox    <= '0;
            r_oy    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pps_pkg::REG_ROW_X:  r_row_x <= i_cfg_data;
                pps_pkg::REG_ROW_Y:  r_row_y <= i_cfg_data;
                pps_pkg::REG_ROW_Z:  r_row_z <= i_cfg_data;
                pps_pkg::REG_ROW_W:  r_row_w <= i_cfg_data;
                pps_pkg::REG_VIEW_W: r_vw    <= i_cfg_data[9:0];
                pps_pkg::REG_VIEW_H: r_vh    <= i_cfg_data[9:0];
                pps_pkg::REG_OFF_X:  r_ox    <= i_cfg_data[9:0];
                pps_pkg::REG_OFF_Y:  r_oy    <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    logic          w_front_adv, w_back_adv, w_fv, w_qv, w_rd, w_bv;
    pps_pkg::t_job w_fjob, w_qjob;
    logic [3:0]    w_cnt;

    // hold the back while the output register is full and stalled
    assign w_back_adv  = !(o_valid && i_stall);
    assign w_rd        = w_qv && w_back_adv;
    // front holds 3 points in flight plus one arriving; queue is 8 deep
    assign w_front_adv = w_cnt <= 4'd4;
    assign o_stall     = !w_front_adv;

    pps_front #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .POS_FRAC_BITS   (POS_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_adv    (w_front_adv),
        .i_row_x  (r_row_x),
        .i_row_y  (r_row_y),
        .i_row_w  (r_row_w),
        .i_size_x (r_vw),
        .i_size_y (r_vh),
        .i_off_x  (r_ox),
        .i_off_y  (r_oy),
        .o_valid  (w_fv),
        .o_job    (w_fjob)
    );

    pps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fv && w_front_adv),
        .i_job   (w_fjob),
        .i_rd    (w_rd),
        .o_valid (w_qv),
        .o_job   (w_qjob),
        .o_count (w_cnt)
    );

    pps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rd),
        .i_job   (w_qjob),
        .i_adv   (w_back_adv),
        .o_valid (w_bv),
        .o_item  (o_item)
    );

    assign o_valid = w_bv;

    // matrix row z is not wired to the front; no clip z is computed
    logic w_row_z_unused;
    assign w_row_z_unused = ^r_row_z;

    // queue never overflows
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_cnt <= 4'd8)
        else $error("queue overflow");
    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("output changed under stall");
    // no read from an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_rd |-> w_cnt != 4'd0)
        else $error("queue underflow");
endmodule
